>>> design/gth_pkg.sv
// ----------------------------------------------------------------------------
// gth_pkg
// Shared sizes, types and codes of the grouped-tag find-or-insert block.
// ----------------------------------------------------------------------------
package gth_pkg;

  // table geometry
  localparam int GROUPS      = 32;
  localparam int GROUP_SLOTS = 16;
  localparam int KEY_BITS    = 64;

  // fixed port field widths
  localparam int IN_KEY_W   = 64;
  localparam int HASH_W     = 32;
  localparam int SLOT_OUT_W = 9;
  localparam int TAG_W      = 8;
  localparam int TAG_BITS   = 7;

  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int LANE_W = $clog2(GROUP_SLOTS);

  localparam logic [TAG_W-1:0] EMPTY_TAG = TAG_W'(8'h80);

  // group selection: mask when the group count is a power of two,
  // otherwise reciprocal multiply with a small correction
  localparam bit          GRP_POW2 = ((GROUPS & (GROUPS - 1)) == 0);
  localparam logic [31:0] GRP_MU   = 32'((64'd1 << 32) / GROUPS);
  localparam logic [31:0] GRP_CNT  = 32'(GROUPS);

  localparam logic [GRP_W:0]   GRP_LIM    = (GRP_W + 1)'(GROUPS);
  localparam logic [GRP_W-1:0] SQ_INIT    = GRP_W'(1 % GROUPS);
  localparam logic [GRP_W-1:0] ODD_INIT   = GRP_W'(3 % GROUPS);
  localparam logic [GRP_W-1:0] LAST_PROBE = GRP_W'(GROUPS - 1);

  typedef logic [GRP_W-1:0]                   grp_t;
  typedef logic [LANE_W-1:0]                  lane_t;
  typedef logic [KEY_BITS-1:0]                key_t;
  typedef logic [TAG_W-1:0]                   tag_t;
  typedef logic [GROUP_SLOTS-1:0][TAG_W-1:0]  row_t;
  typedef logic [GROUP_SLOTS-1:0]             lane_mask_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD_MUL,
    S_MOD_FOLD,
    S_MOD_FIX,
    S_ROW,
    S_SCAN,
    S_CMP,
    S_INS,
    S_NEXT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_FOUND,
    RES_INSERTED,
    RES_FULL
  } res_kind_t;

  typedef struct packed {
    logic      load_in;
    logic      mod_mul;
    logic      mod_fold;
    logic      mod_fix;
    logic      row_rd;
    logic      scan;
    logic      pick;
    logic      ins;
    logic      step;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_empty;
    logic more_hits;
    logic empty_any;
    logic key_eq;
    logic last_probe;
    logic out_hold;
  } stat_t;

endpackage

>>> design/gth_ctrl.sv
// ----------------------------------------------------------------------------
// gth_ctrl
// Sequencer of one lookup: group select, row read, tag scan, key compares,
// insert or next probe, and hand-off to the result register.
// ----------------------------------------------------------------------------
module gth_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  gth_pkg::stat_t stat_i,
  output gth_pkg::cmd_t  cmd_o
);

  gth_pkg::state_t state_r;
  gth_pkg::state_t state_nxt;
  gth_pkg::state_t start_state;
  logic            accept;

  assign start_state = gth_pkg::GRP_POW2 ? gth_pkg::S_ROW : gth_pkg::S_MOD_MUL;

  assign in_stall = !((state_r == gth_pkg::S_IDLE) ||
                      ((state_r == gth_pkg::S_DONE) && !stat_i.out_hold));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gth_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gth_pkg::S_IDLE: begin
        if (accept) state_nxt = start_state;
      end
      gth_pkg::S_MOD_MUL:  state_nxt = gth_pkg::S_MOD_FOLD;
      gth_pkg::S_MOD_FOLD: state_nxt = gth_pkg::S_MOD_FIX;
      gth_pkg::S_MOD_FIX:  state_nxt = gth_pkg::S_ROW;
      gth_pkg::S_ROW:      state_nxt = gth_pkg::S_SCAN;
      gth_pkg::S_SCAN: begin
        if (stat_i.scan_hit)        state_nxt = gth_pkg::S_CMP;
        else if (stat_i.scan_empty) state_nxt = gth_pkg::S_INS;
        else                        state_nxt = gth_pkg::S_NEXT;
      end
      gth_pkg::S_CMP: begin
        if (stat_i.key_eq)         state_nxt = gth_pkg::S_DONE;
        else if (stat_i.more_hits) state_nxt = gth_pkg::S_CMP;
        else if (stat_i.empty_any) state_nxt = gth_pkg::S_INS;
        else                       state_nxt = gth_pkg::S_NEXT;
      end
      gth_pkg::S_INS: state_nxt = gth_pkg::S_DONE;
      gth_pkg::S_NEXT: begin
        if (stat_i.last_probe) state_nxt = gth_pkg::S_DONE;
        else                   state_nxt = gth_pkg::S_ROW;
      end
      gth_pkg::S_DONE: begin
        if (!stat_i.out_hold) begin
          state_nxt = accept ? start_state : gth_pkg::S_IDLE;
        end
      end
      default: state_nxt = gth_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_kind = gth_pkg::RES_FOUND;
    case (state_r)
      gth_pkg::S_IDLE:     cmd_o.load_in  = accept;
      gth_pkg::S_MOD_MUL:  cmd_o.mod_mul  = 1'b1;
      gth_pkg::S_MOD_FOLD: cmd_o.mod_fold = 1'b1;
      gth_pkg::S_MOD_FIX:  cmd_o.mod_fix  = 1'b1;
      gth_pkg::S_ROW:      cmd_o.row_rd   = 1'b1;
      gth_pkg::S_SCAN:     cmd_o.scan     = 1'b1;
      gth_pkg::S_CMP: begin
        if (stat_i.key_eq) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = gth_pkg::RES_FOUND;
        end else if (stat_i.more_hits) begin
          cmd_o.pick = 1'b1;
        end
      end
      gth_pkg::S_INS: begin
        cmd_o.ins      = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = gth_pkg::RES_INSERTED;
      end
      gth_pkg::S_NEXT: begin
        if (stat_i.last_probe) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = gth_pkg::RES_FULL;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      gth_pkg::S_DONE: begin
        cmd_o.out_load = !stat_i.out_hold;
        cmd_o.load_in  = accept;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> design/gth_dp.sv
// ----------------------------------------------------------------------------
// gth_dp
// Datapath: request registers, group arithmetic, tag row and key memories,
// lane scan and the result register.
// ----------------------------------------------------------------------------
module gth_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [gth_pkg::IN_KEY_W-1:0]      in_key,
  input  logic [gth_pkg::HASH_W-1:0]        in_hash,
  input  gth_pkg::cmd_t                     cmd_i,
  output gth_pkg::stat_t                    stat_o,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gth_pkg::SLOT_OUT_W-1:0]    out_slot_index,
  output logic                              out_found,
  output logic                              out_inserted,
  output logic                              out_table_full
);

  localparam int SLOT_W = gth_pkg::GRP_W + gth_pkg::LANE_W;

  function automatic gth_pkg::lane_t first_lane(input gth_pkg::lane_mask_t m);
    gth_pkg::lane_t idx;
    idx = '0;
    for (int i = gth_pkg::GROUP_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) idx = gth_pkg::LANE_W'(i);
    end
    return idx;
  endfunction

  // memories
  gth_pkg::row_t tag_mem [gth_pkg::GROUPS];
  gth_pkg::key_t key_mem [gth_pkg::GROUPS][gth_pkg::GROUP_SLOTS];
  logic [gth_pkg::GROUPS-1:0] row_vld_r;

  // memory read data
  gth_pkg::row_t tag_rd_r;
  logic          vld_rd_r;
  gth_pkg::key_t key_rd_r;

  // request and probe state
  gth_pkg::key_t        key_r,       key_nxt;
  gth_pkg::tag_t        tag_r,       tag_nxt;
  logic [31:0]          hash_r,      hash_nxt;
  logic [31:0]          prod_r,      prod_nxt;
  logic [31:0]          qg_r,        qg_nxt;
  gth_pkg::grp_t        grp_r,       grp_nxt;
  gth_pkg::grp_t        probe_r,     probe_nxt;
  gth_pkg::grp_t        sq_r,        sq_nxt;
  gth_pkg::grp_t        odd_r,       odd_nxt;
  gth_pkg::row_t        row_r,       row_nxt;
  gth_pkg::lane_mask_t  hit_r,       hit_nxt;
  gth_pkg::lane_t       cur_lane_r,  cur_lane_nxt;
  logic                 empty_any_r, empty_any_nxt;
  gth_pkg::lane_t       empty_lane_r, empty_lane_nxt;
  logic [SLOT_W-1:0]    res_slot_r,  res_slot_nxt;
  gth_pkg::res_kind_t   res_kind_r,  res_kind_nxt;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic [gth_pkg::SLOT_OUT_W-1:0]  out_slot_r,  out_slot_nxt;
  logic                            out_found_r, out_found_nxt;
  logic                            out_ins_r,   out_ins_nxt;
  logic                            out_full_r,  out_full_nxt;

  // combinational helpers
  gth_pkg::row_t       row_eff;
  gth_pkg::row_t       row_ins;
  gth_pkg::lane_mask_t hit_vec;
  gth_pkg::lane_mask_t emp_vec;
  gth_pkg::lane_t      pick_lane;
  logic [31:0]         mod_d0, mod_d1, mod_d2;
  logic [gth_pkg::GRP_W:0] grp_sum, sq_sum, odd_s0, odd_s1, odd_s2;

  // a group never written reads as all empty
  assign row_eff = vld_rd_r ? tag_rd_r : {gth_pkg::GROUP_SLOTS{gth_pkg::EMPTY_TAG}};

  always_comb begin
    for (int i = 0; i < gth_pkg::GROUP_SLOTS; i++) begin
      hit_vec[i] = (row_eff[i] == tag_r);
      emp_vec[i] = (row_eff[i] == gth_pkg::EMPTY_TAG);
    end
  end

  assign pick_lane = cmd_i.scan ? first_lane(hit_vec) : first_lane(hit_r);

  always_comb begin
    row_ins               = row_r;
    row_ins[empty_lane_r] = tag_r;
  end

  // reduction remainder is below three group counts
  assign mod_d0 = hash_r - qg_r;
  assign mod_d1 = (mod_d0 >= gth_pkg::GRP_CNT) ? mod_d0 - gth_pkg::GRP_CNT : mod_d0;
  assign mod_d2 = (mod_d1 >= gth_pkg::GRP_CNT) ? mod_d1 - gth_pkg::GRP_CNT : mod_d1;

  // quadratic probe, step kept incrementally as (p+1)^2 mod groups
  assign grp_sum = {1'b0, grp_r} + {1'b0, sq_r};
  assign sq_sum  = {1'b0, sq_r} + {1'b0, odd_r};
  assign odd_s0  = {1'b0, odd_r} + (gth_pkg::GRP_W + 1)'(2);
  assign odd_s1  = (odd_s0 >= gth_pkg::GRP_LIM) ? odd_s0 - gth_pkg::GRP_LIM : odd_s0;
  assign odd_s2  = (odd_s1 >= gth_pkg::GRP_LIM) ? odd_s1 - gth_pkg::GRP_LIM : odd_s1;

  always_comb begin
    key_nxt        = key_r;
    tag_nxt        = tag_r;
    hash_nxt       = hash_r;
    prod_nxt       = prod_r;
    qg_nxt         = qg_r;
    grp_nxt        = grp_r;
    probe_nxt      = probe_r;
    sq_nxt         = sq_r;
    odd_nxt        = odd_r;
    row_nxt        = row_r;
    hit_nxt        = hit_r;
    cur_lane_nxt   = cur_lane_r;
    empty_any_nxt  = empty_any_r;
    empty_lane_nxt = empty_lane_r;
    res_slot_nxt   = res_slot_r;
    res_kind_nxt   = res_kind_r;

    if (cmd_i.load_in) begin
      key_nxt   = in_key[gth_pkg::KEY_BITS-1:0];
      tag_nxt   = {1'b0, in_hash[gth_pkg::TAG_BITS-1:0]};
      hash_nxt  = in_hash;
      grp_nxt   = (gth_pkg::GROUPS == 1) ? '0 : in_hash[gth_pkg::GRP_W-1:0];
      probe_nxt = '0;
      sq_nxt    = gth_pkg::SQ_INIT;
      odd_nxt   = gth_pkg::ODD_INIT;
    end
    if (cmd_i.mod_mul) begin
      prod_nxt = 32'((64'(hash_r) * 64'(gth_pkg::GRP_MU)) >> 32);
    end
    if (cmd_i.mod_fold) begin
      qg_nxt = 32'(64'(prod_r) * 64'(gth_pkg::GRP_CNT));
    end
    if (cmd_i.mod_fix) begin
      grp_nxt = mod_d2[gth_pkg::GRP_W-1:0];
    end
    if (cmd_i.scan) begin
      row_nxt        = row_eff;
      hit_nxt        = hit_vec & (hit_vec - 1'b1);
      cur_lane_nxt   = pick_lane;
      empty_any_nxt  = |emp_vec;
      empty_lane_nxt = first_lane(emp_vec);
    end
    if (cmd_i.pick) begin
      hit_nxt      = hit_r & (hit_r - 1'b1);
      cur_lane_nxt = pick_lane;
    end
    if (cmd_i.step) begin
      grp_nxt   = (grp_sum >= gth_pkg::GRP_LIM) ?
                  gth_pkg::GRP_W'(grp_sum - gth_pkg::GRP_LIM) : gth_pkg::GRP_W'(grp_sum);
      sq_nxt    = (sq_sum >= gth_pkg::GRP_LIM) ?
                  gth_pkg::GRP_W'(sq_sum - gth_pkg::GRP_LIM) : gth_pkg::GRP_W'(sq_sum);
      odd_nxt   = gth_pkg::GRP_W'(odd_s2);
      probe_nxt = probe_r + 1'b1;
    end
    if (cmd_i.res_load) begin
      res_kind_nxt = cmd_i.res_kind;
      case (cmd_i.res_kind)
        gth_pkg::RES_FOUND:    res_slot_nxt = {grp_r, cur_lane_r};
        gth_pkg::RES_INSERTED: res_slot_nxt = {grp_r, empty_lane_r};
        gth_pkg::RES_FULL:     res_slot_nxt = '0;
        default:               res_slot_nxt = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_slot_nxt  = out_slot_r;
    out_found_nxt = out_found_r;
    out_ins_nxt   = out_ins_r;
    out_full_nxt  = out_full_r;
    if (cmd_i.out_load) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt  = gth_pkg::SLOT_OUT_W'(res_slot_r);
      out_found_nxt = (res_kind_r == gth_pkg::RES_FOUND);
      out_ins_nxt   = (res_kind_r == gth_pkg::RES_INSERTED);
      out_full_nxt  = (res_kind_r == gth_pkg::RES_FULL);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd_i.ins) row_vld_r[grp_r] <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    tag_r        <= tag_nxt;
    hash_r       <= hash_nxt;
    prod_r       <= prod_nxt;
    qg_r         <= qg_nxt;
    grp_r        <= grp_nxt;
    probe_r      <= probe_nxt;
    sq_r         <= sq_nxt;
    odd_r        <= odd_nxt;
    row_r        <= row_nxt;
    hit_r        <= hit_nxt;
    cur_lane_r   <= cur_lane_nxt;
    empty_any_r  <= empty_any_nxt;
    empty_lane_r <= empty_lane_nxt;
    res_slot_r   <= res_slot_nxt;
    res_kind_r   <= res_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_found_r  <= out_found_nxt;
    out_ins_r    <= out_ins_nxt;
    out_full_r   <= out_full_nxt;
  end

  // tag row memory, read-modify-write on insert
  always_ff @(posedge clk) begin
    if (cmd_i.ins) tag_mem[grp_r] <= row_ins;
    if (cmd_i.row_rd) begin
      tag_rd_r <= tag_mem[grp_r];
      vld_rd_r <= row_vld_r[grp_r];
    end
  end

  // key memory
  always_ff @(posedge clk) begin
    if (cmd_i.ins) key_mem[grp_r][empty_lane_r] <= key_r;
    if (cmd_i.scan || cmd_i.pick) key_rd_r <= key_mem[grp_r][pick_lane];
  end

  assign stat_o.scan_hit   = |hit_vec;
  assign stat_o.scan_empty = |emp_vec;
  assign stat_o.more_hits  = |hit_r;
  assign stat_o.empty_any  = empty_any_r;
  assign stat_o.key_eq     = (key_rd_r == key_r);
  assign stat_o.last_probe = (probe_r == gth_pkg::LAST_PROBE);
  assign stat_o.out_hold   = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_slot_r;
  assign out_found      = out_found_r;
  assign out_inserted   = out_ins_r;
  assign out_table_full = out_full_r;

`ifndef ASSERT_OFF
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({out_found_r, out_ins_r, out_full_r}))
    else $error("result carries other than one outcome");

  a_ins_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.ins |-> empty_any_r)
    else $error("insert into a group with no free lane");

  a_pick_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pick |-> (hit_r != '0))
    else $error("key read issued with no tag hit left");

  a_grp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.step || cmd_i.mod_fix) |=> ({1'b0, grp_r} < gth_pkg::GRP_LIM))
    else $error("group index out of range after probe step");
`endif

endmodule

>>> design/grouped_tag_hash_find_or_insert.sv
// ----------------------------------------------------------------------------
// grouped_tag_hash_find_or_insert
// Grouped-tag hash table: find a key or insert it into the first free lane.
// ----------------------------------------------------------------------------
// Usage:
//   request channel in_valid/in_stall carries in_key and its precomputed
//   in_hash; the result channel out_valid/out_stall carries out_slot_index
//   and one of out_found, out_inserted, out_table_full.
//   One request is worked at a time. Each extra tag hit in a group costs
//   one more key memory read; each further probe group adds a step, a row
//   read and a scan. Group counts that are not a power of two add a
//   multiply, fold and fix step at the start for the hash reduction.
//   The result sits in an output register; the next request is accepted in
//   the cycle it is handed on, and while out_stall is high the result holds
//   and at most the current request waits in its done state.
//   After reset every group reads as empty through a per-group valid bit,
//   so the table is usable in the first cycle; key memory is not cleared.
// ----------------------------------------------------------------------------
module grouped_tag_hash_find_or_insert (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gth_pkg::IN_KEY_W-1:0]    in_key,
  input  logic [gth_pkg::HASH_W-1:0]      in_hash,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gth_pkg::SLOT_OUT_W-1:0]  out_slot_index,
  output logic                            out_found,
  output logic                            out_inserted,
  output logic                            out_table_full
);

  gth_pkg::cmd_t  cmd;
  gth_pkg::stat_t stat;

  gth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  gth_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_key         (in_key),
    .in_hash        (in_hash),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_found      (out_found),
    .out_inserted   (out_inserted),
    .out_table_full (out_table_full)
  );

endmodule
